/* design/tt2u_pkg.sv */
// ---------------------------------------------------------------------------
// tt2u_pkg
// Shared types and constants for the teletext to UTF-8 decoder.
// ---------------------------------------------------------------------------
package tt2u_pkg;

   localparam int ENTRY_COUNT = 21;       // entries per magazine row
   localparam int CODE_W      = 16;       // code point width

   // request command codes
   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // table write request, issued from the decode stage
   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] data;
   } tbl_wr_type;

endpackage

/* design/tt2u_table.sv */
// ---------------------------------------------------------------------------
// tt2u_table
// National character table: synchronous RAM with a registered read,
// per-entry valid bits cleared by reset, and write-to-read forwarding.
// ---------------------------------------------------------------------------
module tt2u_table #(
   parameter int DEPTH = 168,
   parameter int AW    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   input  tt2u_pkg::tbl_wr_type        wr,
   input  logic [AW-1:0]               wr_addr,
   output logic [tt2u_pkg::CODE_W-1:0] rd_code
);
   import tt2u_pkg::*;

   logic [CODE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [CODE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // a write landing on the address being read wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= (wr.en && (wr_addr == rd_addr)) ? 1'b1 : vld_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   assign rd_code = rd_vld_ff ? rd_data_ff : '0;

endmodule

/* design/teletext_char_to_utf8_core.sv */
// ---------------------------------------------------------------------------
// teletext_char_to_utf8_core
// Teletext packet byte to UTF-8 decoder with per-magazine national table.
// ---------------------------------------------------------------------------
// Flow: an accepted request is registered in the decode stage together with
// its registered table read; the stage's result bytes load the output buffer.
// Throughput: one request per cycle while each gives at most one byte and the
// response side does not stall; a request with more results (up to 4) holds
// back later requests until its last byte is popped from the output buffer.
// Reset: clears stage and output control, skip state, byte count and the
// table valid bits (whole table reads as zero at once); out_limit becomes 256.
// ---------------------------------------------------------------------------
module teletext_char_to_utf8_core #(
   parameter int MAGAZINE_COUNT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [7:0]                  req_packet_byte,
   input  logic [2:0]                  req_magazine,
   input  logic                        req_last_byte,
   input  logic [4:0]                  req_entry_index,
   input  logic [tt2u_pkg::CODE_W-1:0] req_entry_code,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_end_of_string,
   // register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [15:0]                 csr_out_limit
);
   import tt2u_pkg::*;

   localparam int TABLE_DEPTH = MAGAZINE_COUNT * ENTRY_COUNT;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   localparam logic [6:0] CH_CR    = 7'h0d;   // starts a skip
   localparam logic [6:0] CH_ETX   = 7'h0b;   // ends a skip
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_DEL   = 7'h7f;

   typedef enum logic [2:0] {
      SKIP_NONE = 3'b001,
      SKIP_SCAN = 3'b010,
      SKIP_ONE  = 3'b100
   } skip_type;

   // national slot lookup; hit flag in bit 5
   function automatic logic [5:0] national_slot(input logic [6:0] c);
      logic [5:0] r;
      r = '0;
      case (c)
         7'h23: r = {1'b1, 5'd0};
         7'h24: r = {1'b1, 5'd1};
         7'h40: r = {1'b1, 5'd2};
         7'h5b: r = {1'b1, 5'd3};
         7'h5c: r = {1'b1, 5'd4};
         7'h5d: r = {1'b1, 5'd5};
         7'h5e: r = {1'b1, 5'd6};
         7'h5f: r = {1'b1, 5'd7};
         7'h60: r = {1'b1, 5'd8};
         7'h7b: r = {1'b1, 5'd9};
         7'h7c: r = {1'b1, 5'd10};
         7'h7d: r = {1'b1, 5'd11};
         7'h7e: r = {1'b1, 5'd12};
         7'h08: r = {1'b1, 5'd13};
         7'h09: r = {1'b1, 5'd14};
         7'h0a: r = {1'b1, 5'd15};
         7'h0b: r = {1'b1, 5'd16};
         7'h0c: r = {1'b1, 5'd17};
         7'h0e: r = {1'b1, 5'd19};
         7'h0f: r = {1'b1, 5'd20};
         default: r = '0;
      endcase
      return r;
   endfunction

   // ---------------- request decode and table read ----------------
   logic                req_accept;
   logic [6:0]          req_char;
   logic [5:0]          req_slot;
   logic [4:0]          req_idx;
   logic                req_mag_ok;
   logic                req_addr_ok;
   logic [7:0]          req_addr_full;
   logic [TABLE_AW-1:0] req_addr;

   assign req_accept = req_valid && !req_stall;
   assign req_char   = {req_packet_byte[1], req_packet_byte[2], req_packet_byte[3],
                        req_packet_byte[4], req_packet_byte[5], req_packet_byte[6],
                        req_packet_byte[7]};
   assign req_slot   = national_slot(req_char);
   assign req_idx    = (req_command == CMD_LOAD) ? req_entry_index : req_slot[4:0];
   assign req_mag_ok = ({1'b0, req_magazine} < 4'(MAGAZINE_COUNT));
   assign req_addr_ok = req_mag_ok && ((req_command == CMD_LOAD) ?
                        (req_entry_index < 5'(ENTRY_COUNT)) : req_slot[5]);
   assign req_addr_full = 8'(req_magazine) * 8'(ENTRY_COUNT) + 8'(req_idx);
   assign req_addr      = req_addr_full[TABLE_AW-1:0];

   // ---------------- decode stage ----------------
   logic                s1_vld_ff;
   logic                s1_cmd_ff;
   logic [6:0]          s1_char_ff;
   logic                s1_hit_ff;
   logic                s1_ok_ff;
   logic                s1_last_ff;
   logic [CODE_W-1:0]   s1_code_ff;
   logic [TABLE_AW-1:0] s1_addr_ff;

   logic                s1_retire;
   logic [CODE_W-1:0]   tbl_code;
   tbl_wr_type          tbl_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_retire) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= req_command;
         s1_char_ff <= req_char;
         s1_hit_ff  <= req_slot[5];
         s1_ok_ff   <= req_addr_ok;
         s1_last_ff <= req_last_byte;
         s1_code_ff <= req_entry_code;
         s1_addr_ff <= req_addr;
      end
   end

   tt2u_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (TABLE_AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && req_addr_ok),
      .rd_addr (req_addr),
      .wr      (tbl_wr),
      .wr_addr (s1_addr_ff),
      .rd_code (tbl_code)
   );

   // ---------------- state ----------------
   skip_type    skip_ff, skip_in;
   logic [15:0] bw_ff, bw_in;
   logic [15:0] limit_ff;

   logic [CODE_W-1:0] cp_raw;
   logic [CODE_W-1:0] cp;
   logic [1:0]        enc_len;
   logic [7:0]        enc [4];
   logic [17:0]       fit_sum;
   logic              fit;
   logic              idle;
   logic [2:0]        n_body;
   logic              n_term;
   logic [2:0]        n_out;
   logic [7:0]        new_byte [4];
   logic              new_eos  [4];

   assign idle = (skip_ff == SKIP_NONE) && (bw_ff == '0);

   always_comb begin
      if (s1_hit_ff) begin
         cp_raw = s1_ok_ff ? tbl_code : '0;
      end else if ((s1_char_ff > CH_SPACE) && (s1_char_ff != CH_DEL)) begin
         cp_raw = CODE_W'(s1_char_ff);
      end else begin
         cp_raw = CODE_W'(CH_SPACE);
      end
      cp = (cp_raw == '0) ? CODE_W'(CH_SPACE) : cp_raw;
   end

   always_comb begin
      enc[3] = 8'h00;
      if (cp < 16'h0080) begin
         enc_len = 2'd1;
         enc[0]  = cp[7:0];
         enc[1]  = 8'h00;
         enc[2]  = 8'h00;
      end else if (cp < 16'h0800) begin
         enc_len = 2'd2;
         enc[0]  = {3'b110, cp[10:6]};
         enc[1]  = {2'b10, cp[5:0]};
         enc[2]  = 8'h00;
      end else begin
         enc_len = 2'd3;
         enc[0]  = {4'b1110, cp[15:12]};
         enc[1]  = {2'b10, cp[11:6]};
         enc[2]  = {2'b10, cp[5:0]};
      end
      fit_sum = 18'(bw_ff) + 18'(enc_len) + 18'd1;
      fit     = fit_sum < 18'(limit_ff);
   end

   always_comb begin
      skip_in = skip_ff;
      bw_in   = bw_ff;
      n_body  = 3'd0;
      n_term  = 1'b0;
      if (s1_cmd_ff == CMD_DECODE) begin
         case (skip_ff)
            SKIP_SCAN: begin
               if (s1_char_ff == CH_ETX) skip_in = SKIP_ONE;
            end
            SKIP_ONE: begin
               skip_in = SKIP_NONE;
            end
            SKIP_NONE: begin
               if (!s1_hit_ff && (s1_char_ff == CH_CR)) skip_in = SKIP_SCAN;
               if (fit) begin
                  n_body = 3'(enc_len);
                  bw_in  = bw_ff + 16'(enc_len);
               end
            end
            default: begin
               skip_in = SKIP_NONE;
            end
         endcase
         if (s1_last_ff) begin
            n_term  = 1'b1;
            bw_in   = '0;
            skip_in = SKIP_NONE;
         end
      end
      n_out = n_body + 3'(n_term);
   end

   // terminator fills every slot past the encoded bytes
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < n_body) begin
            new_byte[k] = enc[2'(k)];
            new_eos[k]  = 1'b0;
         end else begin
            new_byte[k] = 8'h00;
            new_eos[k]  = 1'b1;
         end
      end
   end

   assign tbl_wr.en   = s1_retire && (s1_cmd_ff == CMD_LOAD) && s1_ok_ff && idle;
   assign tbl_wr.data = s1_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= SKIP_NONE;
         bw_ff   <= '0;
      end else if (s1_retire) begin
         skip_ff <= skip_in;
         bw_ff   <= bw_in;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_out_limit;
      end
   end

   // ---------------- output shift register ----------------
   logic [7:0] obuf_byte_ff [4];
   logic       obuf_eos_ff  [4];
   logic [2:0] ocnt_ff;
   logic       rsp_pop;
   logic       obuf_load;

   assign rsp_valid         = (ocnt_ff != 3'd0);
   assign rsp_out_byte      = obuf_byte_ff[0];
   assign rsp_end_of_string = obuf_eos_ff[0];
   assign rsp_pop           = rsp_valid && !rsp_stall;

   assign obuf_load = (ocnt_ff == 3'd0) || ((ocnt_ff == 3'd1) && rsp_pop);
   assign s1_retire = s1_vld_ff && ((n_out == 3'd0) || obuf_load);
   assign req_stall = s1_vld_ff && !s1_retire;

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
      end else if (s1_retire && (n_out != 3'd0)) begin
         ocnt_ff <= n_out;
      end else if (rsp_pop) begin
         ocnt_ff <= ocnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_retire && (n_out != 3'd0)) begin
         obuf_byte_ff <= new_byte;
         obuf_eos_ff  <= new_eos;
      end else if (rsp_pop) begin
         for (int k = 0; k < 3; k++) begin
            obuf_byte_ff[k] <= obuf_byte_ff[k+1];
            obuf_eos_ff[k]  <= obuf_eos_ff[k+1];
         end
      end
   end

   // ---------------- assertions ----------------
   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 3'd4)
      else $error("output count out of range");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_out_byte == 8'h00)
      else $error("terminator byte not zero");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && (n_out != 3'd0))
      else $error("request stalled without pending output");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      s1_retire && (s1_cmd_ff == CMD_DECODE) && s1_last_ff |=>
         (bw_ff == '0) && (skip_ff == SKIP_NONE))
      else $error("string end did not clear state");

endmodule
